>>> rtl/set_assoc_cache_fifo_replace_macros.svh
// Assertion macros for the cache top level.
`ifndef SET_ASSOC_CACHE_FIFO_REPLACE_MACROS_SVH
`define SET_ASSOC_CACHE_FIFO_REPLACE_MACROS_SVH
`ifndef SYNTHESIS
`define SACFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sacfr: same-cycle check failed");
`define SACFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sacfr: next-cycle check failed");
`else
`define SACFR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SACFR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/sacfr_pkg.sv
// Shared types, op codes and default sizes of the set-associative cache.
package sacfr_pkg;

    localparam int NUM_SETS_DEF  = 8;
    localparam int NUM_WAYS_DEF  = 4;
    localparam int TAG_BITS_DEF  = 20;
    localparam int DATA_BITS_DEF = 32;

    localparam int BNUM_W    = 24;
    localparam int TAG_IN_W  = 20;
    localparam int DATA_IN_W = 32;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_PEEK   = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]           op;
        logic [BNUM_W-1:0]    block_num;
        logic [TAG_IN_W-1:0]  tag;
        logic                 dirty_in;
        logic [DATA_IN_W-1:0] data_in;
        logic                 valid_in;
        logic [2:0]           set_sel;
        logic [1:0]           way_sel;
    } item_t;

    typedef struct packed {
        logic                 hit;
        logic [1:0]           hit_way;
        logic                 out_valid;
        logic                 out_dirty;
        logic [TAG_IN_W-1:0]  out_tag;
        logic [BNUM_W-1:0]    out_block_num;
        logic [DATA_IN_W-1:0] out_data;
        logic                 writeback_needed;
    } result_t;

    typedef struct packed {
        logic rd_en;
        logic st_we;
        logic pl_we;
    } mem_ctrl_t;

endpackage

>>> rtl/set_assoc_cache_fifo_replace.sv
// Top level of the set-associative cache with per-set FIFO replacement.
// One item is handled at a time: after the input transfer the set index
// (block_num mod NUM_SETS) is formed by a reciprocal multiply and a
// multiply-subtract, one registered step each; the control then moves from
// S_MOD to S_READ, where the set's status and payload rows are read from
// synchronous memory, and on to S_EVAL, where the result is formed and any
// insert written back, before the next item is taken. The result sits in
// an output register, so the next item can be taken while it waits; that
// item then holds in S_EVAL until the register is free. After reset the
// status memory is cleared one set per cycle before the first item is taken.
`include "set_assoc_cache_fifo_replace_macros.svh"

module set_assoc_cache_fifo_replace #(
    parameter int NUM_SETS  = sacfr_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS  = sacfr_pkg::NUM_WAYS_DEF,
    parameter int TAG_BITS  = sacfr_pkg::TAG_BITS_DEF,
    parameter int DATA_BITS = sacfr_pkg::DATA_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [23:0] block_num,
    input  logic [19:0] tag,
    input  logic        dirty_in,
    input  logic [31:0] data_in,
    input  logic        valid_in,
    input  logic [2:0]  set_sel,
    input  logic [1:0]  way_sel,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        hit,
    output logic [1:0]  hit_way,
    output logic        out_valid,
    output logic        out_dirty,
    output logic [19:0] out_tag,
    output logic [23:0] out_block_num,
    output logic [31:0] out_data,
    output logic        writeback_needed
);

    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ST_W  = 2 * NUM_WAYS + WAY_W;
    localparam int PL_W  = NUM_WAYS * (TAG_BITS + sacfr_pkg::BNUM_W + DATA_BITS);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_MOD   = 5'b00100,
        S_READ  = 5'b01000,
        S_EVAL  = 5'b10000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [SET_W-1:0]     clr_cnt_reg;
    logic [SET_W-1:0]     clr_cnt_next;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    logic                 res_load;
    logic                 in_xfer;
    sacfr_pkg::item_t     item_reg;
    sacfr_pkg::result_t   res_reg;
    sacfr_pkg::result_t   eval_res;
    sacfr_pkg::mem_ctrl_t ctrl;
    logic                 mod_done;
    logic [SET_W-1:0]     mod_set;
    logic [SET_W+2:0]     peek_set_wide;
    logic [SET_W-1:0]     addr;
    logic [ST_W-1:0]      st_rdata;
    logic [ST_W-1:0]      st_new;
    logic [ST_W-1:0]      st_wdata;
    logic [PL_W-1:0]      pl_rdata;
    logic [PL_W-1:0]      pl_new;
    logic                 wr_en;

    assign in_xfer = in_valid && in_ready;

    sacfr_setmod #(
        .NUM_SETS(NUM_SETS)
    ) u_setmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_xfer),
        .value   (block_num),
        .done    (mod_done),
        .set_idx (mod_set)
    );

    assign peek_set_wide = {{SET_W{1'b0}}, item_reg.set_sel};

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            addr = clr_cnt_reg;
        end
        else if (item_reg.op == sacfr_pkg::OP_PEEK)
        begin
            addr = peek_set_wide[SET_W-1:0];
        end
        else
        begin
            addr = mod_set;
        end
    end

    assign st_wdata = (state_reg == S_CLEAR) ? '0 : st_new;

    sacfr_store #(
        .NUM_SETS  (NUM_SETS),
        .NUM_WAYS  (NUM_WAYS),
        .TAG_BITS  (TAG_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_store (
        .clk      (clk),
        .ctrl     (ctrl),
        .addr     (addr),
        .st_wdata (st_wdata),
        .pl_wdata (pl_new),
        .st_rdata (st_rdata),
        .pl_rdata (pl_rdata)
    );

    sacfr_eval #(
        .NUM_SETS  (NUM_SETS),
        .NUM_WAYS  (NUM_WAYS),
        .TAG_BITS  (TAG_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_eval (
        .item   (item_reg),
        .st_row (st_rdata),
        .pl_row (pl_rdata),
        .res    (eval_res),
        .st_new (st_new),
        .pl_new (pl_new),
        .wr_en  (wr_en)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_load       = 1'b0;
        in_ready       = 1'b0;
        ctrl           = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctrl.st_we   = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ctrl.rd_en = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                // Hold until the output register is free, then write back.
                if (!res_valid_reg || res_ready)
                begin
                    res_load       = 1'b1;
                    res_valid_next = 1'b1;
                    ctrl.st_we     = wr_en;
                    ctrl.pl_we     = wr_en;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.op        <= op;
            item_reg.block_num <= block_num;
            item_reg.tag       <= tag;
            item_reg.dirty_in  <= dirty_in;
            item_reg.data_in   <= data_in;
            item_reg.valid_in  <= valid_in;
            item_reg.set_sel   <= set_sel;
            item_reg.way_sel   <= way_sel;
        end
        if (res_load)
        begin
            res_reg <= eval_res;
        end
    end

    assign res_valid        = res_valid_reg;
    assign hit              = res_reg.hit;
    assign hit_way          = res_reg.hit_way;
    assign out_valid        = res_reg.out_valid;
    assign out_dirty        = res_reg.out_dirty;
    assign out_tag          = res_reg.out_tag;
    assign out_block_num    = res_reg.out_block_num;
    assign out_data         = res_reg.out_data;
    assign writeback_needed = res_reg.writeback_needed;

    `SACFR_ASSERT_NXT(a_xfer_starts_mod, clk, rst_n, in_xfer, state_reg == S_MOD)
    `SACFR_ASSERT_IMP(a_mod_done_in_mod, clk, rst_n, mod_done, state_reg == S_MOD)
    `SACFR_ASSERT_IMP(a_result_from_eval, clk, rst_n, $rose(res_valid_reg),
                      $past(state_reg) == S_EVAL)
    `SACFR_ASSERT_NXT(a_eval_fills_output, clk, rst_n,
                      (state_reg == S_EVAL) && (!res_valid_reg || res_ready),
                      res_valid_reg && (state_reg == S_IDLE))

endmodule

>>> rtl/sacfr_setmod.sv
// Residue of the block number by the set count through reciprocal multiplication.
module sacfr_setmod #(
    parameter int NUM_SETS = sacfr_pkg::NUM_SETS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic [sacfr_pkg::BNUM_W-1:0]                  value,
    output logic                                          done,
    output logic [((NUM_SETS > 1) ? $clog2(NUM_SETS) : 1)-1:0] set_idx
);

    localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SHIFT   = sacfr_pkg::BNUM_W + $clog2(NUM_SETS);
    localparam int RECIP_W = sacfr_pkg::BNUM_W + 1;
    localparam int PROD_W  = sacfr_pkg::BNUM_W + RECIP_W;
    localparam int QUOT_W  = PROD_W - SHIFT;
    localparam logic [63:0] RECIP_VAL =
        ((64'd1 << SHIFT) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam logic [sacfr_pkg::BNUM_W-1:0] MODULUS = sacfr_pkg::BNUM_W'(NUM_SETS);

    logic [sacfr_pkg::BNUM_W-1:0] val_reg;
    logic [PROD_W-1:0]            prod;
    logic [QUOT_W-1:0]            quot_reg;
    logic [sacfr_pkg::BNUM_W-1:0] rem_full;
    logic [SET_W-1:0]             rem_reg;
    logic                         stage_reg;
    logic                         quot_vld_reg;
    logic                         done_reg;

    // Rounded-up reciprocal gives the exact quotient for every 24-bit value.
    always_comb
    begin
        prod     = PROD_W'(val_reg) * PROD_W'(RECIP);
        rem_full = val_reg - sacfr_pkg::BNUM_W'(quot_reg) * MODULUS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg    <= 1'b0;
            quot_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            stage_reg    <= start;
            quot_vld_reg <= stage_reg;
            done_reg     <= quot_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= value;
        end
        if (stage_reg)
        begin
            quot_reg <= prod[PROD_W-1 -: QUOT_W];
        end
        if (quot_vld_reg)
        begin
            rem_reg <= rem_full[SET_W-1:0];
        end
    end

    assign done    = done_reg;
    assign set_idx = rem_reg;

endmodule

>>> rtl/sacfr_store.sv
// Set status memory and way payload memory, one row per set.
module sacfr_store #(
    parameter int NUM_SETS  = sacfr_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS  = sacfr_pkg::NUM_WAYS_DEF,
    parameter int TAG_BITS  = sacfr_pkg::TAG_BITS_DEF,
    parameter int DATA_BITS = sacfr_pkg::DATA_BITS_DEF
) (
    input  logic                 clk,
    input  sacfr_pkg::mem_ctrl_t ctrl,
    input  logic [((NUM_SETS > 1) ? $clog2(NUM_SETS) : 1)-1:0] addr,
    input  logic [2*NUM_WAYS + ((NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1)-1:0] st_wdata,
    input  logic [NUM_WAYS*(TAG_BITS+sacfr_pkg::BNUM_W+DATA_BITS)-1:0] pl_wdata,
    output logic [2*NUM_WAYS + ((NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1)-1:0] st_rdata,
    output logic [NUM_WAYS*(TAG_BITS+sacfr_pkg::BNUM_W+DATA_BITS)-1:0] pl_rdata
);

    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ST_W  = 2 * NUM_WAYS + WAY_W;
    localparam int PL_W  = NUM_WAYS * (TAG_BITS + sacfr_pkg::BNUM_W + DATA_BITS);

    logic [ST_W-1:0] st_mem [NUM_SETS];
    logic [PL_W-1:0] pl_mem [NUM_SETS];

    always_ff @(posedge clk)
    begin
        if (ctrl.st_we)
        begin
            st_mem[addr] <= st_wdata;
        end
        if (ctrl.pl_we)
        begin
            pl_mem[addr] <= pl_wdata;
        end
        if (ctrl.rd_en)
        begin
            st_rdata <= st_mem[addr];
            pl_rdata <= pl_mem[addr];
        end
    end

endmodule

>>> rtl/sacfr_eval.sv
// Tag compare, entry report and insert update on one set row.
module sacfr_eval #(
    parameter int NUM_SETS  = sacfr_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS  = sacfr_pkg::NUM_WAYS_DEF,
    parameter int TAG_BITS  = sacfr_pkg::TAG_BITS_DEF,
    parameter int DATA_BITS = sacfr_pkg::DATA_BITS_DEF
) (
    input  sacfr_pkg::item_t   item,
    input  logic [2*NUM_WAYS + ((NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1)-1:0] st_row,
    input  logic [NUM_WAYS*(TAG_BITS+sacfr_pkg::BNUM_W+DATA_BITS)-1:0] pl_row,
    output sacfr_pkg::result_t res,
    output logic [2*NUM_WAYS + ((NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1)-1:0] st_new,
    output logic [NUM_WAYS*(TAG_BITS+sacfr_pkg::BNUM_W+DATA_BITS)-1:0] pl_new,
    output logic               wr_en
);

    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ST_W  = 2 * NUM_WAYS + WAY_W;
    localparam int PW    = TAG_BITS + sacfr_pkg::BNUM_W + DATA_BITS;

    logic [NUM_WAYS-1:0] way_valid;
    logic [NUM_WAYS-1:0] way_dirty;
    logic [NUM_WAYS-1:0] hit_vec;
    logic [WAY_W-1:0]    fifo_ptr;
    logic [WAY_W-1:0]    ptr_next;
    logic [WAY_W-1:0]    hit_idx;
    logic [WAY_W-1:0]    peek_way;
    logic [WAY_W-1:0]    sel;
    logic [WAY_W+1:0]    way_sel_wide;
    logic [WAY_W+1:0]    hit_way_wide;
    logic [TAG_BITS-1:0] tag_k;
    logic [TAG_BITS+sacfr_pkg::TAG_IN_W-1:0]   tag_in_wide;
    logic [TAG_BITS+sacfr_pkg::TAG_IN_W-1:0]   tag_out_wide;
    logic [DATA_BITS+sacfr_pkg::DATA_IN_W-1:0] data_in_wide;
    logic [DATA_BITS+sacfr_pkg::DATA_IN_W-1:0] data_out_wide;
    logic [PW-1:0]       entry;
    logic [PW-1:0]       new_entry;
    logic                hit_any;
    logic                peek_ok;
    logic                report;

    assign way_valid = st_row[NUM_WAYS-1:0];
    assign way_dirty = st_row[2*NUM_WAYS-1:NUM_WAYS];
    assign fifo_ptr  = st_row[ST_W-1 -: WAY_W];

    always_comb
    begin
        tag_in_wide = {{TAG_BITS{1'b0}}, item.tag};
        tag_k       = tag_in_wide[TAG_BITS-1:0];

        for (int w = 0; w < NUM_WAYS; w++)
        begin
            hit_vec[w] = way_valid[w] &&
                         (pl_row[w*PW + DATA_BITS + sacfr_pkg::BNUM_W +: TAG_BITS] == tag_k);
        end

        // Lowest matching way wins.
        hit_idx = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_idx = WAY_W'(w);
            end
        end
        hit_any      = |hit_vec;
        hit_way_wide = {2'b00, hit_idx};

        way_sel_wide = {{WAY_W{1'b0}}, item.way_sel};
        peek_way     = way_sel_wide[WAY_W-1:0];
        peek_ok      = (32'(item.set_sel) < NUM_SETS) && (32'(item.way_sel) < NUM_WAYS);

        ptr_next = (fifo_ptr == WAY_W'(NUM_WAYS - 1)) ? '0 : fifo_ptr + 1'b1;

        sel    = '0;
        report = 1'b0;
        wr_en  = 1'b0;
        res    = '0;
        unique case (item.op)
            sacfr_pkg::OP_LOOKUP:
            begin
                sel         = hit_idx;
                report      = hit_any;
                res.hit     = hit_any;
                res.hit_way = hit_way_wide[1:0];
            end
            sacfr_pkg::OP_INSERT:
            begin
                sel                  = fifo_ptr;
                report               = 1'b1;
                wr_en                = 1'b1;
                res.writeback_needed = way_valid[fifo_ptr] && way_dirty[fifo_ptr];
            end
            sacfr_pkg::OP_PEEK:
            begin
                sel    = peek_way;
                report = peek_ok;
            end
            default:
            begin
                sel = '0;
            end
        endcase

        entry         = pl_row[int'(sel)*PW +: PW];
        tag_out_wide  = {{sacfr_pkg::TAG_IN_W{1'b0}}, entry[PW-1 -: TAG_BITS]};
        data_out_wide = {{sacfr_pkg::DATA_IN_W{1'b0}}, entry[DATA_BITS-1:0]};

        // Invalid entries show their marks but zero contents.
        if (report)
        begin
            res.out_valid = way_valid[sel];
            res.out_dirty = way_dirty[sel];
            if (way_valid[sel])
            begin
                res.out_tag       = tag_out_wide[sacfr_pkg::TAG_IN_W-1:0];
                res.out_block_num = entry[DATA_BITS +: sacfr_pkg::BNUM_W];
                res.out_data      = data_out_wide[sacfr_pkg::DATA_IN_W-1:0];
            end
        end

        data_in_wide = {{DATA_BITS{1'b0}}, item.data_in};
        new_entry    = {tag_k, item.block_num, data_in_wide[DATA_BITS-1:0]};

        st_new                           = st_row;
        st_new[int'(fifo_ptr)]           = item.valid_in;
        st_new[NUM_WAYS + int'(fifo_ptr)] = item.dirty_in;
        st_new[ST_W-1 -: WAY_W]          = ptr_next;

        pl_new                          = pl_row;
        pl_new[int'(fifo_ptr)*PW +: PW] = new_entry;
    end

endmodule
